### rtl/pcm_to_pwm_duty_with_averager_unit_macros.svh
// Assertion helpers used by pcmpwm_ctrl.
`ifndef PCM_TO_PWM_DUTY_WITH_AVERAGER_UNIT_MACROS_SVH
`define PCM_TO_PWM_DUTY_WITH_AVERAGER_UNIT_MACROS_SVH

// same-cycle implication
`define PCMPWM_ASSERT_IMP(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define PCMPWM_ASSERT_NXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/pcmpwm_pkg.sv
`default_nettype none
package pcmpwm_pkg;

   localparam int SAMPLE_W = 16;
   localparam int CCR_W    = 12;
   localparam int PROD_W   = SAMPLE_W + CCR_W;
   localparam int CSR_W    = 1;

   localparam logic [SAMPLE_W:0] FULL_SCALE = 17'h0FFFF;

   localparam logic [CSR_W-1:0] CSR_CCR_MIN = 1'b0;
   localparam logic [CSR_W-1:0] CSR_CCR_MAX = 1'b1;

   localparam logic KIND_CCR = 1'b0;
   localparam logic KIND_POP = 1'b1;

   typedef enum logic [2:0] {
      FUNC_SAMPLE = 3'd0,
      FUNC_POP    = 3'd1,
      FUNC_START  = 3'd2,
      FUNC_STOP   = 3'd3,
      FUNC_MUTE   = 3'd4
   } func_type;

   typedef enum logic [1:0] {
      RES_NONE,
      RES_CCR,
      RES_SILENCE,
      RES_POP
   } res_type;

   typedef struct packed {
      res_type res;
      logic    hit;
   } op_type;

endpackage
`default_nettype wire

### rtl/pcmpwm_ram.sv
`default_nettype none
module pcmpwm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

### rtl/pcmpwm_ctrl.sv
`default_nettype none
`include "pcm_to_pwm_duty_with_averager_unit_macros.svh"
module pcmpwm_ctrl
   import pcmpwm_pkg::*;
#(
   parameter int AVG_SAMPLES = 8,
   parameter int QUEUE_DEPTH = 64
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       acc,
   input  wire logic [2:0]                 func,
   input  wire logic signed [SAMPLE_W-1:0] left_sample,
   input  wire logic signed [SAMPLE_W-1:0] right_sample,
   output logic                            hazard,
   output op_type                          op,
   output logic [2*SAMPLE_W-1:0]           rd_data
);

   localparam int IDX_W   = $clog2(QUEUE_DEPTH);
   localparam int AVG_LG  = $clog2(AVG_SAMPLES);
   localparam int CNT_W   = AVG_LG + 1;
   localparam int SUM_W   = SAMPLE_W + AVG_LG + 1;
   localparam int SHIFT   = SUM_W + AVG_LG + 1;
   localparam int RECIP_W = SHIFT - AVG_LG + 2;
   localparam int MUL_W   = SUM_W + RECIP_W;
   localparam longint unsigned RECIP = (64'd1 << SHIFT) / AVG_SAMPLES + 1;
   localparam logic [RECIP_W-1:0] RECIP_V = RECIP_W'(RECIP);

   func_type f;

   logic                    playing_ff, playing_in;
   logic [CNT_W-1:0]        cnt_ff, cnt_in, cnt_nx;
   logic signed [SUM_W-1:0] sum_l_ff, sum_l_in, sum_l_nx;
   logic signed [SUM_W-1:0] sum_r_ff, sum_r_in, sum_r_nx;
   logic [IDX_W-1:0]        push_ff, push_in, push_nx;
   logic [IDX_W-1:0]        pop_ff, pop_in, pop_nx;

   logic smp, grp_done, push_go, pop_hit, pop_go;

   logic                    p1_valid_ff;
   logic [IDX_W-1:0]        p1_addr_ff;
   logic signed [SUM_W-1:0] p1_sum_l_ff, p1_sum_r_ff;
   logic [SUM_W-1:0]        mag_l, mag_r;

   logic                    p2_valid_ff;
   logic [IDX_W-1:0]        p2_addr_ff;
   logic                    p2_neg_l_ff, p2_neg_r_ff;
   logic [MUL_W-1:0]        p2_prod_l_ff, p2_prod_r_ff;
   logic [SAMPLE_W:0]       q_l, q_r;
   logic [SAMPLE_W-1:0]     avg_l, avg_r;

   assign f        = func_type'(func);
   assign smp      = acc && (f == FUNC_SAMPLE) && playing_ff;
   assign cnt_nx   = cnt_ff + CNT_W'(1);
   assign grp_done = (cnt_nx == CNT_W'(AVG_SAMPLES));
   assign sum_l_nx = sum_l_ff + {{(SUM_W-SAMPLE_W){left_sample[SAMPLE_W-1]}}, left_sample};
   assign sum_r_nx = sum_r_ff + {{(SUM_W-SAMPLE_W){right_sample[SAMPLE_W-1]}}, right_sample};
   assign push_nx  = (push_ff == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : push_ff + IDX_W'(1);
   assign pop_nx   = (pop_ff == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : pop_ff + IDX_W'(1);
   assign push_go  = smp && grp_done && (push_nx != pop_ff);
   assign pop_hit  = (pop_ff != push_ff);
   assign pop_go   = acc && (f == FUNC_POP) && pop_hit;

   // a pop waits until in-flight averages are written
   assign hazard = (f == FUNC_POP) && (p1_valid_ff || p2_valid_ff);

   always_comb begin
      op.hit = pop_hit;
      unique case (f) inside
         FUNC_SAMPLE: begin
            op.res = playing_ff ? RES_CCR : RES_NONE;
         end
         FUNC_POP:                op.res = RES_POP;
         FUNC_STOP, FUNC_MUTE:    op.res = RES_SILENCE;
         default:                 op.res = RES_NONE;
      endcase
   end

   always_comb begin
      playing_in = playing_ff;
      cnt_in     = cnt_ff;
      sum_l_in   = sum_l_ff;
      sum_r_in   = sum_r_ff;
      push_in    = push_ff;
      pop_in     = pop_ff;
      if (acc) begin
         unique case (f)
            FUNC_SAMPLE: begin
               if (playing_ff) begin
                  if (grp_done) begin
                     cnt_in   = '0;
                     sum_l_in = '0;
                     sum_r_in = '0;
                     if (push_go) begin
                        push_in = push_nx;
                     end
                  end else begin
                     cnt_in   = cnt_nx;
                     sum_l_in = sum_l_nx;
                     sum_r_in = sum_r_nx;
                  end
               end
            end
            FUNC_POP: begin
               if (pop_hit) begin
                  pop_in = pop_nx;
               end
            end
            FUNC_START: begin
               playing_in = 1'b1;
               cnt_in     = '0;
               sum_l_in   = '0;
               sum_r_in   = '0;
               push_in    = '0;
               pop_in     = '0;
            end
            FUNC_STOP: begin
               playing_in = 1'b0;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         playing_ff <= 1'b0;
         cnt_ff     <= '0;
         sum_l_ff   <= '0;
         sum_r_ff   <= '0;
         push_ff    <= '0;
         pop_ff     <= '0;
      end else begin
         playing_ff <= playing_in;
         cnt_ff     <= cnt_in;
         sum_l_ff   <= sum_l_in;
         sum_r_ff   <= sum_r_in;
         push_ff    <= push_in;
         pop_ff     <= pop_in;
      end
   end

   // divide group sum by AVG_SAMPLES: reciprocal multiply on the magnitude
   assign mag_l = p1_sum_l_ff[SUM_W-1] ? SUM_W'(-p1_sum_l_ff) : SUM_W'(p1_sum_l_ff);
   assign mag_r = p1_sum_r_ff[SUM_W-1] ? SUM_W'(-p1_sum_r_ff) : SUM_W'(p1_sum_r_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff <= 1'b0;
         p2_valid_ff <= 1'b0;
      end else begin
         p1_valid_ff <= push_go;
         p2_valid_ff <= p1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (push_go) begin
         p1_addr_ff  <= push_ff;
         p1_sum_l_ff <= sum_l_nx;
         p1_sum_r_ff <= sum_r_nx;
      end
      if (p1_valid_ff) begin
         p2_addr_ff   <= p1_addr_ff;
         p2_neg_l_ff  <= p1_sum_l_ff[SUM_W-1];
         p2_neg_r_ff  <= p1_sum_r_ff[SUM_W-1];
         p2_prod_l_ff <= MUL_W'(mag_l) * MUL_W'(RECIP_V);
         p2_prod_r_ff <= MUL_W'(mag_r) * MUL_W'(RECIP_V);
      end
   end

   assign q_l   = p2_prod_l_ff[SHIFT +: SAMPLE_W+1];
   assign q_r   = p2_prod_r_ff[SHIFT +: SAMPLE_W+1];
   assign avg_l = p2_neg_l_ff ? SAMPLE_W'(-q_l) : SAMPLE_W'(q_l);
   assign avg_r = p2_neg_r_ff ? SAMPLE_W'(-q_r) : SAMPLE_W'(q_r);

   pcmpwm_ram #(
      .WIDTH (2*SAMPLE_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (p2_valid_ff),
      .wr_addr (p2_addr_ff),
      .wr_data ({avg_l, avg_r}),
      .rd_en   (pop_go),
      .rd_addr (pop_ff),
      .rd_data (rd_data)
   );

   `PCMPWM_ASSERT_IMP(a_pop_after_write, clock, reset, pop_go, !(p1_valid_ff || p2_valid_ff), "pop read overlaps pending write")
   `PCMPWM_ASSERT_NXT(a_push_keeps_gap, clock, reset, push_go, push_ff != pop_ff, "push filled the empty slot")
   `PCMPWM_ASSERT_IMP(a_cnt_range, clock, reset, 1'b1, cnt_ff < CNT_W'(AVG_SAMPLES), "group count out of range")

endmodule
`default_nettype wire

### rtl/pcmpwm_out.sv
`default_nettype none
module pcmpwm_out
   import pcmpwm_pkg::*;
(
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       acc,
   input  wire op_type                     op,
   input  wire logic signed [SAMPLE_W-1:0] left_sample,
   input  wire logic signed [SAMPLE_W-1:0] right_sample,
   input  wire logic [CCR_W-1:0]           ccr_min,
   input  wire logic [CCR_W-1:0]           ccr_max,
   input  wire logic [2*SAMPLE_W-1:0]      rd_data,
   output logic                            b_free,
   output logic                            rsp_valid,
   input  wire logic                       rsp_stall,
   output logic                            rsp_kind,
   output logic [CCR_W-1:0]                rsp_ccr_left,
   output logic [CCR_W-1:0]                rsp_ccr_right,
   output logic                            rsp_pop_valid,
   output logic signed [SAMPLE_W-1:0]      rsp_avg_left,
   output logic signed [SAMPLE_W-1:0]      rsp_avg_right
);

   logic [CCR_W-1:0]    span;
   logic [SAMPLE_W-1:0] u_l, u_r;

   logic                b_valid_ff, b_valid_in;
   res_type             b_res_ff;
   logic                b_hit_ff;
   logic [PROD_W-1:0]   b_prod_l_ff, b_prod_r_ff;

   logic                advance;
   logic [CCR_W-1:0]    q0_l, q0_r, q_l, q_r, mid;
   logic [SAMPLE_W:0]   rem_l, rem_r;
   logic [CCR_W:0]      mid_sum;

   logic                  out_valid_ff;
   logic                  kind_ff, kind_in;
   logic [CCR_W-1:0]      ccr_l_ff, ccr_l_in, ccr_r_ff, ccr_r_in;
   logic                  pop_valid_ff, pop_valid_in;
   logic [SAMPLE_W-1:0]   avg_l_ff, avg_l_in, avg_r_ff, avg_r_in;

   assign span = (ccr_max >= ccr_min) ? ccr_max - ccr_min : '0;
   assign u_l  = {~left_sample[SAMPLE_W-1], left_sample[SAMPLE_W-2:0]};
   assign u_r  = {~right_sample[SAMPLE_W-1], right_sample[SAMPLE_W-2:0]};

   assign advance = !out_valid_ff || !rsp_stall;
   assign b_free  = !b_valid_ff || advance;

   always_comb begin
      b_valid_in = b_valid_ff;
      if (acc) begin
         b_valid_in = (op.res != RES_NONE);
      end else if (advance) begin
         b_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         b_valid_ff <= b_valid_in;
         if (advance) begin
            out_valid_ff <= b_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (acc) begin
         b_res_ff    <= op.res;
         b_hit_ff    <= op.hit;
         b_prod_l_ff <= PROD_W'(u_l) * PROD_W'(span);
         b_prod_r_ff <= PROD_W'(u_r) * PROD_W'(span);
      end
   end

   // x / 65535 as (x >> 16) plus one correction step
   assign q0_l  = b_prod_l_ff[PROD_W-1:SAMPLE_W];
   assign q0_r  = b_prod_r_ff[PROD_W-1:SAMPLE_W];
   assign rem_l = (SAMPLE_W+1)'(b_prod_l_ff[SAMPLE_W-1:0]) + (SAMPLE_W+1)'(q0_l);
   assign rem_r = (SAMPLE_W+1)'(b_prod_r_ff[SAMPLE_W-1:0]) + (SAMPLE_W+1)'(q0_r);
   assign q_l   = q0_l + CCR_W'(rem_l >= FULL_SCALE);
   assign q_r   = q0_r + CCR_W'(rem_r >= FULL_SCALE);

   assign mid_sum = (CCR_W+1)'(ccr_min) + (CCR_W+1)'(ccr_max);
   assign mid     = mid_sum[CCR_W:1];

   always_comb begin
      kind_in      = KIND_CCR;
      ccr_l_in     = '0;
      ccr_r_in     = '0;
      pop_valid_in = 1'b0;
      avg_l_in     = '0;
      avg_r_in     = '0;
      case (b_res_ff)
         RES_CCR: begin
            ccr_l_in = ccr_min + q_l;
            ccr_r_in = ccr_min + q_r;
         end
         RES_SILENCE: begin
            ccr_l_in = mid;
            ccr_r_in = mid;
         end
         RES_POP: begin
            kind_in      = KIND_POP;
            pop_valid_in = b_hit_ff;
            if (b_hit_ff) begin
               avg_l_in = rd_data[2*SAMPLE_W-1:SAMPLE_W];
               avg_r_in = rd_data[SAMPLE_W-1:0];
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (advance && b_valid_ff) begin
         kind_ff      <= kind_in;
         ccr_l_ff     <= ccr_l_in;
         ccr_r_ff     <= ccr_r_in;
         pop_valid_ff <= pop_valid_in;
         avg_l_ff     <= avg_l_in;
         avg_r_ff     <= avg_r_in;
      end
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_kind      = kind_ff;
   assign rsp_ccr_left  = ccr_l_ff;
   assign rsp_ccr_right = ccr_r_ff;
   assign rsp_pop_valid = pop_valid_ff;
   assign rsp_avg_left  = avg_l_ff;
   assign rsp_avg_right = avg_r_ff;

endmodule
`default_nettype wire

### rtl/pcm_to_pwm_duty_with_averager_unit.sv
`default_nettype none
// channel | direction | handshake           | payload
// req     | in        | req_valid/req_stall | func, left_sample, right_sample
// rsp     | out       | rsp_valid/rsp_stall | kind, ccr_left/right, pop_valid, avg_left/right
// csr     | in        | csr_valid/csr_ready | csr_index, csr_data
//
// One beat per cycle while req_stall is low; a request beat is registered in the buffer stage and then in the
// result stage before its result leaves. Group averages pass a two-stage divide before the queue RAM write,
// so a pop beat right after a group closes is held while either divide stage is busy.
// Reset is synchronous; ccr_min/ccr_max return to 30/570, queue empty, stopped.
// rsp_stall backs up through the result stage and then stalls req.
module pcm_to_pwm_duty_with_averager_unit
   import pcmpwm_pkg::*;
#(
   parameter int AVG_SAMPLES = 8,
   parameter int QUEUE_DEPTH = 64
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output logic                            req_stall,
   input  wire logic [2:0]                 req_func,
   input  wire logic signed [SAMPLE_W-1:0] req_left_sample,
   input  wire logic signed [SAMPLE_W-1:0] req_right_sample,
   output logic                            rsp_valid,
   input  wire logic                       rsp_stall,
   output logic                            rsp_kind,
   output logic [CCR_W-1:0]                rsp_ccr_left,
   output logic [CCR_W-1:0]                rsp_ccr_right,
   output logic                            rsp_pop_valid,
   output logic signed [SAMPLE_W-1:0]      rsp_avg_left,
   output logic signed [SAMPLE_W-1:0]      rsp_avg_right,
   input  wire logic                       csr_valid,
   output logic                            csr_ready,
   input  wire logic [CSR_W-1:0]           csr_index,
   input  wire logic [CCR_W-1:0]           csr_data
);

   logic [CCR_W-1:0]      ccr_min_ff, ccr_max_ff;
   logic                  acc, hazard, b_free;
   op_type                op;
   logic [2*SAMPLE_W-1:0] rd_data;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         ccr_min_ff <= CCR_W'(30);
         ccr_max_ff <= CCR_W'(570);
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_CCR_MIN: ccr_min_ff <= csr_data;
            CSR_CCR_MAX: ccr_max_ff <= csr_data;
            default: begin
            end
         endcase
      end
   end

   assign req_stall = !b_free || hazard;
   assign acc       = req_valid && !req_stall;

   pcmpwm_ctrl #(
      .AVG_SAMPLES (AVG_SAMPLES),
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .acc          (acc),
      .func         (req_func),
      .left_sample  (req_left_sample),
      .right_sample (req_right_sample),
      .hazard       (hazard),
      .op           (op),
      .rd_data      (rd_data)
   );

   pcmpwm_out u_out (
      .clock         (clock),
      .reset         (reset),
      .acc           (acc),
      .op            (op),
      .left_sample   (req_left_sample),
      .right_sample  (req_right_sample),
      .ccr_min       (ccr_min_ff),
      .ccr_max       (ccr_max_ff),
      .rd_data       (rd_data),
      .b_free        (b_free),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_kind      (rsp_kind),
      .rsp_ccr_left  (rsp_ccr_left),
      .rsp_ccr_right (rsp_ccr_right),
      .rsp_pop_valid (rsp_pop_valid),
      .rsp_avg_left  (rsp_avg_left),
      .rsp_avg_right (rsp_avg_right)
   );

endmodule
`default_nettype wire
